/* rtl/sto_pkg.sv */
// Shared constants and types for the sine tone oscillator.
package sto_pkg;

  // Default sizes of the phase accumulator and the quarter-wave table
  localparam int PhaseBitsDef = 32;
  localparam int TableBitsDef = 10;

  // Channel copies per frame are capped by the channel limit and by the result limit
  localparam int MaxChannels = 8;
  localparam int ResultLimit = 8;
  localparam int CountLimit  = (MaxChannels < ResultLimit) ? MaxChannels : ResultLimit;

  // Field widths
  localparam int SampleBits   = 16;
  localparam int MagBits      = 15;
  localparam int AmpBits      = 15;
  localparam int ChanBits     = 3;
  localparam int CountBits    = 4;
  localparam int CfgIndexBits = 4;
  localparam int CfgDataBits  = 32;
  localparam int InDataBits   = 8;
  localparam int OutDataBits  = 24;

  // Register indexes
  localparam logic [CfgIndexBits-1:0] RegAmplitude      = 4'd0;
  localparam logic [CfgIndexBits-1:0] RegPhaseIncrement = 4'd1;
  localparam logic [CfgIndexBits-1:0] RegPhaseOffset    = 4'd2;
  localparam logic [CfgIndexBits-1:0] RegChannelCount   = 4'd3;

  // Reset values of the registers
  localparam logic [AmpBits-1:0]   AmpReset   = 15'd32767;
  localparam logic [CountBits-1:0] CountReset = 4'd2;

  // One finished frame handed to the channel replicator
  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic [CountBits-1:0]  count;
  } frame_t;

endpackage

/* rtl/sto_rom.sv */
// Quarter-wave sine table in unsigned Q0.15 with a registered read port.
module sto_rom import sto_pkg::*; #(
  parameter int TABLE_BITS = TableBitsDef
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [TABLE_BITS:0]   addr_i,
  output logic [MagBits-1:0]    data_o
);

  localparam int Depth = (1 << TABLE_BITS) + 1;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] RoundHalf = 64'd536870912;
  localparam logic [63:0] MagMax    = 64'd32767;

  typedef logic [Depth-1:0][MagBits-1:0] rom_t;

  // sin(x) for x in [0, pi/2], Q2.30 in and out, alternating Taylor series
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 9; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        7:       term = term / 64'd210;
        8:       term = term / 64'd272;
        default: term = term / 64'd342;
      endcase
      if ((n & 1) != 0) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Entry k of the table, rounded and clamped to full scale
  function automatic logic [MagBits-1:0] quarter_sine(input int k);
    logic [63:0] x;
    logic [63:0] v;
    x = (HalfPiQ30 * 64'(k)) >> TABLE_BITS;
    v = (sine_q30(x) * MagMax + RoundHalf) >> 30;
    if (v > MagMax) begin
      v = MagMax;
    end
    return v[MagBits-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < Depth; k++) begin
      r[k] = quarter_sine(k);
    end
    return r;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [MagBits-1:0] data_q;

  // Synchronous read, held while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= Rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

/* rtl/sto_emit.sv */
// Output register that repeats each frame's sample once per channel.
module sto_emit import sto_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  frame_valid_i,
  input  frame_t                frame_i,
  output logic                  frame_ready_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [SampleBits-1:0] sample_o,
  output logic [ChanBits-1:0]   channel_o,
  output logic                  last_o
);

  logic                  valid_q;
  logic [SampleBits-1:0] sample_q;
  logic [ChanBits-1:0]   chan_q;
  logic [CountBits-1:0]  count_q;
  logic                  last_q;
  logic                  load;
  logic                  next_copy;
  logic [CountBits-1:0]  chan_wide;

  // Load a new frame when empty or when the final copy leaves
  assign load      = !valid_q || (ready_i && last_q);
  assign next_copy = valid_q && ready_i && !last_q;
  assign chan_wide = {1'b0, chan_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= frame_valid_i;
    end
  end

  // Copy payload: channel index steps while the sample holds
  always_ff @(posedge clk_i) begin
    if (next_copy) begin
      chan_q <= chan_q + 1'b1;
      last_q <= (chan_wide + 4'd2) == count_q;
    end else if (load && frame_valid_i) begin
      sample_q <= frame_i.sample;
      count_q  <= frame_i.count;
      chan_q   <= '0;
      last_q   <= frame_i.count == 4'd1;
    end
  end

  assign frame_ready_o = load;
  assign valid_o       = valid_q;
  assign sample_o      = sample_q;
  assign channel_o     = chan_q;
  assign last_o        = last_q;

  // The last flag marks exactly the final channel of the frame
  a_last_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (last_q == ((chan_wide + 4'd1) == count_q)))
    else $error("last flag does not match channel count");

  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (chan_wide < count_q))
    else $error("channel index beyond channel count");

  // After a non-final transfer the next copy follows at once
  a_next_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_copy |=> (valid_q && (chan_q == $past(chan_q) + 1'b1)))
    else $error("channel copy skipped");

  a_sample_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_copy |=> $stable(sample_q))
    else $error("sample changed inside a frame");

endmodule

/* rtl/sine_tone_oscillator_core.sv */
// Top level of the sine tone oscillator: registers, phase accumulator, lookup and product.
//
// Usage: each transfer on the s_axis channel with tdata bit 0 set requests one frame;
// a transfer with bit 0 clear is taken and produces nothing. A frame is one 16-bit
// sample, amplitude * sin(phase + phase_offset), sent on m_axis once per channel
// (channel_count copies, 1 to 8), with the channel index in tdata and tlast on the
// final copy. The phase then advances by phase_increment, wrapping modulo a turn.
// Registers are written over the cfg channel (index 0 amplitude, 1 phase_increment,
// 2 phase_offset, 3 channel_count); write them only while no frame is in flight, though
// the block itself does not enforce this; cfg_ready is always high. A request's angle is
// registered as it is taken, followed by the table read, multiply and output register.
// Throughput: one copy per cycle while the receiver is ready, and the next frame
// follows with no gap; the product stage hands over in the same cycle the final
// copy leaves. Requests are taken while earlier frames are still going out.
// Reset clears the pipeline, sets the phase to zero and the registers to their
// defaults. A stalled m_axis receiver holds the current copy; the pipeline fills
// behind it and s_axis_tready drops once the product stage is full and waiting.
module sine_tone_oscillator_core import sto_pkg::*; #(
  parameter int PHASE_BITS = PhaseBitsDef,
  parameter int TABLE_BITS = TableBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Request stream
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [InDataBits-1:0]   s_axis_tdata_i,   // [0] frame_request, [7:1] zero
  // Sample stream
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [OutDataBits-1:0]  m_axis_tdata_o,   // [15:0] sample, [18:16] channel, [23:19] zero
  output logic                    m_axis_tlast_o,
  // Register writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i
);

  localparam int CfgCopy = (PHASE_BITS < CfgDataBits) ? PHASE_BITS : CfgDataBits;
  localparam logic [TABLE_BITS:0] QuarterSize = (TABLE_BITS + 1)'(1 << TABLE_BITS);

  logic [AmpBits-1:0]    amp_q;
  logic [PHASE_BITS-1:0] inc_q;
  logic [PHASE_BITS-1:0] off_q;
  logic [CountBits-1:0]  chan_cfg_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [PHASE_BITS-1:0] acc_q;
  logic                  v1_q;
  logic                  v2_q;
  logic                  v3_q;
  logic                  neg2_q;
  logic [SampleBits-1:0] sample3_q;
  logic                  en;
  logic                  in_xfer;
  logic                  frame_ready;
  logic [TABLE_BITS-1:0] idx;
  logic [TABLE_BITS:0]   rom_addr;
  logic [MagBits-1:0]    mag;
  logic [2*MagBits-1:0]  prod_full;
  logic [SampleBits-1:0] prod;
  logic [CountBits-1:0]  count_eff;
  frame_t                frame;

  assign cfg_ready_o = 1'b1;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q      <= AmpReset;
      inc_q      <= '0;
      off_q      <= '0;
      chan_cfg_q <= CountReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegAmplitude:      amp_q      <= cfg_data_i[AmpBits-1:0];
        RegPhaseIncrement: inc_q      <= PHASE_BITS'(cfg_data_i[CfgCopy-1:0]);
        RegPhaseOffset:    off_q      <= PHASE_BITS'(cfg_data_i[CfgCopy-1:0]);
        RegChannelCount:   chan_cfg_q <= cfg_data_i[CountBits-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances while the product stage is free or being handed over
  assign en              = !v3_q || frame_ready;
  assign s_axis_tready_o = en;
  assign in_xfer         = s_axis_tvalid_i && en && s_axis_tdata_i[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      phase_q <= '0;
    end else begin
      if (en) begin
        v1_q <= in_xfer;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
      if (in_xfer) begin
        phase_q <= phase_q + inc_q;
      end
    end
  end

  // Stage 1: lookup angle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      acc_q <= phase_q + off_q;
    end
  end

  // Stage 2: table address folds the odd quadrants
  assign idx      = acc_q[PHASE_BITS-3 -: TABLE_BITS];
  assign rom_addr = acc_q[PHASE_BITS-2] ? (QuarterSize - {1'b0, idx}) : {1'b0, idx};

  sto_rom #(
    .TABLE_BITS(TABLE_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (en),
    .addr_i (rom_addr),
    .data_o (mag)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg2_q <= acc_q[PHASE_BITS-1];
    end
  end

  // Stage 3: scale by amplitude, truncate, then apply the sign
  assign prod_full = amp_q * mag;
  assign prod      = {1'b0, prod_full[2*MagBits-1:MagBits]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sample3_q <= neg2_q ? (16'd0 - prod) : prod;
    end
  end

  // Channel copies per frame, zero treated as one and larger values capped at CountLimit
  always_comb begin
    if (chan_cfg_q == 4'd0) begin
      count_eff = 4'd1;
    end else if (chan_cfg_q > CountBits'(CountLimit)) begin
      count_eff = CountBits'(CountLimit);
    end else begin
      count_eff = chan_cfg_q;
    end
  end

  assign frame.sample = sample3_q;
  assign frame.count  = count_eff;

  logic [SampleBits-1:0] out_sample;
  logic [ChanBits-1:0]   out_chan;

  sto_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (v3_q),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .valid_o       (m_axis_tvalid_o),
    .ready_i       (m_axis_tready_i),
    .sample_o      (out_sample),
    .channel_o     (out_chan),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(OutDataBits - SampleBits - ChanBits){1'b0}}, out_chan, out_sample};

  // A full product stage blocks new requests until the replicator takes it
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !frame_ready) |=> v3_q)
    else $error("frame lost in product stage");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !frame_ready) |-> !s_axis_tready_o)
    else $error("request taken while product stage full");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[0]) |=> $stable(phase_q))
    else $error("phase moved without a frame request");

endmodule

/* bench/sine_tone_oscillator_checker.sv */
// Sample predictor and checker for the sine tone oscillator streams.
module sine_tone_oscillator_checker import sto_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  input  logic                    s_axis_tready_i,
  input  logic [InDataBits-1:0]   s_axis_tdata_i,   // [0] frame_request, [7:1] zero
  input  logic                    m_axis_tvalid_i,
  input  logic                    m_axis_tready_i,
  input  logic [OutDataBits-1:0]  m_axis_tdata_i,   // [15:0] sample, [18:16] channel, [23:19] zero
  input  logic                    m_axis_tlast_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             pending_copies_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuarterSize = 1 << TableBitsDef;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam int PrintCap = 100;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic [ChanBits-1:0]   channel;
    logic                  last;
  } tone_copy_t;

  // Quarter-wave sine in unsigned Q0.15, entries 0..QuarterSize
  logic [MagBits-1:0] quarter_wave [0:QuarterSize];

  // Shadow registers and phase accumulator
  logic [AmpBits-1:0]      amp_q;
  logic [PhaseBitsDef-1:0] step_q;
  logic [PhaseBitsDef-1:0] offset_q;
  logic [CountBits-1:0]    count_q;
  logic [PhaseBitsDef-1:0] phase_q;

  tone_copy_t expected_copies [$];

  initial mismatch_count_o = 0;
  initial pending_copies_o = 0;

  // sin(x) for 0 <= x <= pi/2, Q2.30 in and out, alternating series
  function automatic longint unsigned taylor_sine(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 9; n++) begin
      term = (term * x2) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  initial begin
    longint unsigned x;
    longint unsigned v;
    for (int k = 0; k <= QuarterSize; k++) begin
      x = (HalfPiQ30 * longint'(k)) / longint'(QuarterSize);
      v = (taylor_sine(x) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      quarter_wave[k] = v[MagBits-1:0];
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count_o = mismatch_count_o + 1;
    if (mismatch_count_o <= PrintCap) begin
      $display("%0t tone check: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    end
  endtask

  // One frame: look up the sine, scale, copy per channel, then advance the phase
  task automatic predict_frame();
    logic [PhaseBitsDef-1:0] angle;
    logic [1:0]              quad;
    logic [TableBitsDef-1:0] idx;
    logic [MagBits-1:0]      mag;
    logic [2*MagBits-1:0]    product;
    logic [SampleBits-1:0]   magnitude;
    int                      copies;
    tone_copy_t              copy;
    angle = phase_q + offset_q;
    quad = angle[PhaseBitsDef-1 -: 2];
    idx = angle[PhaseBitsDef-3 -: TableBitsDef];
    mag = quad[0] ? quarter_wave[QuarterSize - int'(idx)] : quarter_wave[idx];
    product = amp_q * mag;
    magnitude = {1'b0, product[2*MagBits-1:MagBits]};
    copies = (count_q == 0) ? 1 : (int'(count_q) > CountLimit) ? CountLimit : int'(count_q);
    for (int ch = 0; ch < copies; ch++) begin
      copy.sample = quad[1] ? -magnitude : magnitude;
      copy.channel = ch[ChanBits-1:0];
      copy.last = (ch + 1 == copies);
      expected_copies.push_back(copy);
    end
    phase_q = phase_q + step_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tone_copy_t want;
    if (!rst_ni) begin
      amp_q = AmpReset;
      step_q = '0;
      offset_q = '0;
      count_q = CountReset;
      phase_q = '0;
      expected_copies.delete();
    end else begin
      // register writes; unused indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegAmplitude:      amp_q = cfg_data_i[AmpBits-1:0];
          RegPhaseIncrement: step_q = cfg_data_i[PhaseBitsDef-1:0];
          RegPhaseOffset:    offset_q = cfg_data_i[PhaseBitsDef-1:0];
          RegChannelCount:   count_q = cfg_data_i[CountBits-1:0];
          default: ;
        endcase
      end
      // frame requests; a clear request bit is taken and does nothing
      if (s_axis_tvalid_i && s_axis_tready_i && s_axis_tdata_i[0]) begin
        predict_frame();
      end
      // compare each sample transfer with the oldest expected copy
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_copies.size() == 0) begin
          report_mismatch("copy with no frame pending", int'(m_axis_tdata_i), 0);
        end else begin
          want = expected_copies.pop_front();
          if (m_axis_tdata_i[SampleBits-1:0] != want.sample)
            report_mismatch("sample", int'(m_axis_tdata_i[SampleBits-1:0]), int'(want.sample));
          if (m_axis_tdata_i[SampleBits +: ChanBits] != want.channel)
            report_mismatch("channel", int'(m_axis_tdata_i[SampleBits +: ChanBits]),
                            int'(want.channel));
          if (m_axis_tlast_i !== want.last)
            report_mismatch("last", int'(m_axis_tlast_i), int'(want.last));
        end
      end
    end
    pending_copies_o = expected_copies.size();
  end

endmodule

/* bench/sine_tone_oscillator_core_test.sv */
// Stimulus, flow control and verdict for the sine tone oscillator.
module sine_tone_oscillator_core_test;
  import sto_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 4000;
  localparam int SettleCycles = 8;
  localparam int TailCycles = 20;
  localparam logic [CfgIndexBits-1:0] RegUnusedFirst = RegChannelCount + 1'b1;
  localparam logic [CfgIndexBits-1:0] RegUnusedLast = {CfgIndexBits{1'b1}};

  logic clk = 1'b0;
  logic rst_n;

  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [InDataBits-1:0]   s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OutDataBits-1:0]  m_axis_tdata;
  logic                    m_axis_tlast;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index;
  logic [CfgDataBits-1:0]  cfg_data;

  int unsigned mismatches;
  int unsigned pending_copies;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sine_tone_oscillator_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  sine_tone_oscillator_checker tone_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .m_axis_tlast_i   (m_axis_tlast),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .pending_copies_o (pending_copies)
  );

  // Sample receiver: random back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(input logic request);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataBits-1){1'b0}}, request};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Wait for all expected copies, then let in-flight empty requests drain
  task automatic wait_drained(input int settle);
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_copies != 0) @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIndexBits-1:0] index,
                                input logic [CfgDataBits-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Reprogram all registers while idle; a stray write to an unused index goes last
  task automatic program_tone(input logic [CfgDataBits-1:0] amp, input logic [CfgDataBits-1:0] step,
                              input logic [CfgDataBits-1:0] offset,
                              input logic [CfgDataBits-1:0] count, input bit stray_write);
    wait_drained(SettleCycles);
    write_register(RegAmplitude, amp);
    write_register(RegPhaseIncrement, step);
    write_register(RegPhaseOffset, offset);
    write_register(RegChannelCount, count);
    if (stray_write) begin
      write_register(CfgIndexBits'($urandom_range(RegUnusedFirst, RegUnusedLast)), $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // Random settings, extremes included, then a burst of requests
  task automatic run_segment(input int items);
    logic [CfgDataBits-1:0] amp;
    logic [CfgDataBits-1:0] step;
    logic [CfgDataBits-1:0] offset;
    logic [CfgDataBits-1:0] count;
    amp = $urandom;
    case ($urandom_range(0, 3))
      0: amp[AmpBits-1:0] = '0;
      1: amp[AmpBits-1:0] = '1;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: step = '0;
      1: step = '1;
      2: step = $urandom_range(0, 32'h00ff_ffff);
      default: step = $urandom;
    endcase
    case ($urandom_range(0, 3))
      0: offset = '0;
      1: offset = '1;
      default: offset = $urandom;
    endcase
    count = $urandom;
    count[CountBits-1:0] = CountBits'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                  : $urandom_range(1, CountLimit));
    program_tone(amp, step, offset, count, $urandom_range(0, 3) == 0);
    repeat (items) send_request($urandom_range(0, 99) >= 12);
  endtask

  initial begin
    rst_n = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_axis_tready = 1'b0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults, with an empty request
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b0);
    // Quarter-turn steps walk through all four quadrants at full scale
    program_tone(32'h0000_7fff, 32'h4000_0000, 32'h0, 32'd8, 1'b0);
    repeat (5) send_request(1'b1);
    send_request(1'b0);
    // Zero amplitude, zero channel count, last table entry then wrap
    program_tone(32'h0, 32'h0010_0000, 32'hfff0_0000, 32'd0, 1'b0);
    repeat (2) send_request(1'b1);
    // All ones everywhere: amplitude masked, channel count saturated
    program_tone(32'hffff_ffff, 32'hffff_ffff, 32'h3ff0_0000, 32'hffff_ffff, 1'b0);
    repeat (3) send_request(1'b1);
    // Unit amplitude, channel count just past the limit
    program_tone(32'h1, 32'h4000_0000, 32'h7ff0_0000, 32'd9, 1'b0);
    repeat (2) send_request(1'b1);
    // Single channel, half-turn offset, then a write to an unused index
    program_tone(32'd16384, 32'h1234_5678, 32'h8000_0000, 32'd1, 1'b1);
    repeat (3) send_request(1'b1);

    // Random part under three flow-control profiles
    send_idle_pct = 23;
    recv_idle_pct = 88;
    repeat (6) run_segment($urandom_range(15, 35));
    send_idle_pct = 88;
    recv_idle_pct = 23;
    repeat (6) run_segment($urandom_range(15, 35));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (6) run_segment($urandom_range(15, 35));

    wait_drained(TailCycles);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sto_pkg.sv
rtl/sto_rom.sv
rtl/sto_emit.sv
rtl/sine_tone_oscillator_core.sv
bench/sine_tone_oscillator_checker.sv
bench/sine_tone_oscillator_core_test.sv
